FILE: rtl/rdf_pkg.sv
`default_nettype none
package rdf_pkg;

  localparam int MAX_RADIX = 16;
  localparam int StepW     = 3;
  localparam int DigitsN   = 32;

  localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;
  localparam logic [7:0]  CHAR_LOW   = 8'd32;
  localparam logic [7:0]  CHAR_HIGH  = 8'd126;

  localparam logic [4:0]  RADIX_RST       = 5'd10;
  localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0] DIGITS_HIGH_RST = 64'h0000000000003938;

  typedef enum logic [1:0] {
    CFG_RADIX       = 2'd0,
    CFG_DIGITS_LOW  = 2'd1,
    CFG_DIGITS_HIGH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_DIV_INIT,
    OP_DIV_BYTE,
    OP_PUSH,
    OP_SIGN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_WAIT,
    COND_CHK_MORE,
    COND_BAD,
    COND_BYTE_MORE,
    COND_MORE_DIGITS,
    COND_DIGITS_LEFT
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic chk_more;
    logic bad;
    logic byte_more;
    logic more_digits;
    logic digits_left;
  } stat_t;

  typedef struct packed {
    logic [3:0] quo;
    logic [3:0] rem;
  } nib_div_t;

  // microprogram: jump to target when the condition holds, else next step
  function automatic ctrl_t ucode_rom(input logic [StepW-1:0] addr);
    ctrl_t w;
    unique case (addr)
      3'd0: w = '{op: OP_LOAD,     cond: COND_WAIT,        target: 3'd0};
      3'd1: w = '{op: OP_CHECK,    cond: COND_CHK_MORE,    target: 3'd1};
      3'd2: w = '{op: OP_DIV_INIT, cond: COND_BAD,         target: 3'd0};
      3'd3: w = '{op: OP_DIV_BYTE, cond: COND_BYTE_MORE,   target: 3'd3};
      3'd4: w = '{op: OP_PUSH,     cond: COND_MORE_DIGITS, target: 3'd3};
      3'd5: w = '{op: OP_SIGN,     cond: COND_NEVER,       target: 3'd0};
      3'd6: w = '{op: OP_EMIT,     cond: COND_DIGITS_LEFT, target: 3'd6};
      3'd7: w = '{op: OP_NONE,     cond: COND_ALWAYS,      target: 3'd0};
      default: w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: 3'd0};
    endcase
    return w;
  endfunction

  // one radix digit of long division over a 4-bit slice
  function automatic nib_div_t div_nibble(input logic [3:0] rem, input logic [3:0] nib,
                                          input logic [4:0] radix);
    logic [8:0] v;
    logic [8:0] prod;
    logic [8:0] diff;
    nib_div_t   res;
    v       = {1'b0, rem, nib};
    diff    = v;
    res.quo = '0;
    for (int k = 1; k < 16; k++) begin
      prod = {4'b0, radix} * 9'(k);
      if (prod <= v) begin
        res.quo = 4'(k);
        diff    = v - prod;
      end
    end
    res.rem = diff[3:0];
    return res;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [127:0] alpha, input logic [3:0] idx);
    return alpha[{idx, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/radix_digit_formatter.sv
`default_nettype none
// Writes a signed 32-bit value as characters, most significant digit first, in the radix
// held in radix_q, using the alphabet held in digits_low/digits_high. Pulse start
// while busy is low; busy stays high until the whole run is out. Each character appears
// for exactly one cycle with out_valid_o, and last_o marks the final one; the receiver
// cannot stall, so it must take every strobe. A bad alphabet gives no characters. An item
// runs as a load, one check per alphabet character, then for each digit four byte-wide
// long-division steps and one push, then the sign step and one emit step per digit; a new
// item is taken only once busy falls. Configuration writes are held off (cfg_ready_o low)
// while busy or start is high.
module radix_digit_formatter
  import rdf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] value_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  output logic                    out_valid_o,
  output logic [6:0]              out_char_o,
  output logic                    last_o
);

  logic [4:0]  radix_q;
  logic [63:0] digits_low_q;
  logic [63:0] digits_high_q;
  op_e         op;
  stat_t       stat;

  assign cfg_ready_o = !busy && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= RADIX_RST;
      digits_low_q  <= DIGITS_LOW_RST;
      digits_high_q <= DIGITS_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RADIX:       radix_q       <= cfg_data_i[4:0];
        CFG_DIGITS_LOW:  digits_low_q  <= cfg_data_i;
        CFG_DIGITS_HIGH: digits_high_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rdf_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .op_o   (op),
    .busy_o (busy)
  );

  rdf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .value_i     (value_i),
    .radix_i     (radix_q),
    .alpha_i     ({digits_high_q, digits_low_q}),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

FILE: rtl/rdf_useq.sv
`default_nettype none
module rdf_useq
  import rdf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire stat_t stat_i,
  output op_e        op_o,
  output logic       busy_o
);

  logic [StepW-1:0] pc_q, pc_d;
  ctrl_t            word;
  logic             taken;

  assign word   = ucode_rom(pc_q);
  assign op_o   = word.op;
  assign busy_o = (pc_q != '0);

  always_comb begin
    unique case (word.cond)
      COND_NEVER:       taken = 1'b0;
      COND_ALWAYS:      taken = 1'b1;
      COND_WAIT:        taken = !start;
      COND_CHK_MORE:    taken = stat_i.chk_more;
      COND_BAD:         taken = stat_i.bad;
      COND_BYTE_MORE:   taken = stat_i.byte_more;
      COND_MORE_DIGITS: taken = stat_i.more_digits;
      COND_DIGITS_LEFT: taken = stat_i.digits_left;
      default:          taken = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = taken ? word.target : pc_q + StepW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rdf_datapath.sv
`default_nettype none
module rdf_datapath
  import rdf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire op_e                op_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [4:0]         radix_i,
  input  wire logic [127:0]       alpha_i,
  output stat_t                   stat_o,
  output logic                    out_valid_o,
  output logic [6:0]              out_char_o,
  output logic                    last_o
);

  logic [31:0] w_q, w_d;
  logic        neg_q, neg_d;
  logic        bad_q, bad_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  rem_q, rem_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [5:0]  nd_q, nd_d;
  logic [3:0]  digs_q [DigitsN];
  logic        dig_we;
  logic        out_valid_q, out_valid_d;
  logic [6:0]  out_char_q, out_char_d;
  logic        out_last_q, out_last_d;

  logic        range_ok;
  logic [7:0]  cur_char;
  logic        char_bad;
  logic        dup;
  nib_div_t    hi, lo;
  logic [5:0]  nd_m1;
  logic [7:0]  emit_char;

  assign range_ok  = (radix_i >= 5'd2) && (radix_i <= 5'(MAX_RADIX));
  assign cur_char  = alpha_char(alpha_i, idx_q);
  assign char_bad  = (cur_char < CHAR_LOW) || (cur_char > CHAR_HIGH) ||
                     (cur_char == CHAR_PLUS) || (cur_char == CHAR_MINUS);
  assign hi        = div_nibble(rem_q, w_q[31:28], radix_i);
  assign lo        = div_nibble(hi.rem, w_q[27:24], radix_i);
  assign nd_m1     = nd_q - 6'd1;
  assign emit_char = alpha_char(alpha_i, digs_q[nd_m1[4:0]]);

  // duplicates against the later characters in use
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < 16; j++) begin
      if ((4'(j) > idx_q) && (5'(j) < radix_i) && (alpha_char(alpha_i, 4'(j)) == cur_char)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.chk_more    = range_ok && (({1'b0, idx_q} + 5'd1) < radix_i);
    stat_o.bad         = bad_q;
    stat_o.byte_more   = (cnt_q != 2'd3);
    stat_o.more_digits = (w_q != '0) && (nd_q < 6'(DigitsN - 1));
    stat_o.digits_left = (nd_q != 6'd1);
  end

  always_comb begin
    w_d         = w_q;
    neg_d       = neg_q;
    bad_d       = bad_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    nd_d        = nd_q;
    dig_we      = 1'b0;
    out_valid_d = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (op_i)
      OP_NONE: begin
      end
      OP_LOAD: begin
        w_d   = value_i[31] ? (32'd0 - $unsigned(value_i)) : $unsigned(value_i);
        neg_d = value_i[31];
        bad_d = !range_ok;
        idx_d = '0;
      end
      OP_CHECK: begin
        bad_d = bad_q | char_bad | dup;
        idx_d = idx_q + 4'd1;
      end
      OP_DIV_INIT: begin
        rem_d = '0;
        cnt_d = '0;
        nd_d  = '0;
      end
      OP_DIV_BYTE: begin
        w_d   = {w_q[23:0], hi.quo, lo.quo};
        rem_d = lo.rem;
        cnt_d = cnt_q + 2'd1;
      end
      OP_PUSH: begin
        dig_we = 1'b1;
        nd_d   = nd_q + 6'd1;
        rem_d  = '0;
        cnt_d  = '0;
      end
      OP_SIGN: begin
        out_valid_d = neg_q;
        out_char_d  = CHAR_MINUS[6:0];
        out_last_d  = 1'b0;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_char_d  = emit_char[6:0];
        out_last_d  = (nd_q == 6'd1);
        nd_d        = nd_m1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q       <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bad_q       <= bad_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      nd_q        <= nd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    neg_q      <= neg_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (dig_we) begin
      digs_q[nd_q[4:0]] <= rem_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_EMIT) |-> (nd_q != 6'd0))
    else $error("digit emitted from an empty stack");

  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_PUSH) |-> (nd_q < 6'(DigitsN)))
    else $error("digit stack overflow");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((op_i == OP_DIV_BYTE) && !bad_q) |-> ({1'b0, rem_q} < radix_i))
    else $error("division remainder not below radix");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past((op_i == OP_SIGN) || (op_i == OP_EMIT)))
    else $error("character strobe outside an emit step");

endmodule
`default_nettype wire

FILE: sim/radix_digit_formatter_test.sv
`default_nettype none
module radix_digit_formatter_test;
  import rdf_pkg::*;

  localparam int SETTLE_CYCLES = 210;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] value_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               out_valid_o;
  logic [6:0]         out_char_o;
  logic               last_o;

  logic [4:0]   radix_len;
  logic [127:0] alphabet;
  char_t        pending_chars[$];
  int           errors;
  int           items_sent;
  int           chars_seen;
  int           cfg_writes;
  int           alphabet_loads;
  int           cycles;
  int           idle_pct;

  radix_digit_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("radix_digit_formatter verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_chars
    char_t want;
    if (rst_ni && out_valid_o) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        errors++;
        $error("unexpected character: out_char 0x%02h last %0b", out_char_o, last_o);
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch) begin
          errors++;
          $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $error("last: expected %0b, got %0b", want.last, last_o);
        end
      end
    end
  end

  function automatic logic [7:0] glyph(input int idx);
    return alphabet[idx*8 +: 8];
  endfunction

  function automatic bit alphabet_usable();
    logic [7:0] c;
    if (radix_len < 2 || radix_len > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix_len; i++) begin
      c = glyph(i);
      if (c < CHAR_LOW || c > CHAR_HIGH || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < radix_len; j++)
        if (glyph(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_chars(input logic [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digs[$];
    logic [7:0]  c;
    if (!alphabet_usable()) return;
    mag = v[31] ? -v : v;
    do begin
      digs.push_front(4'(mag % radix_len));
      mag = mag / radix_len;
    end while (mag != 0);
    if (v[31]) pending_chars.push_back('{ch: CHAR_MINUS[6:0], last: 1'b0});
    foreach (digs[k]) begin
      c = glyph(digs[k]);
      pending_chars.push_back('{ch: c[6:0], last: (k == digs.size() - 1)});
    end
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RADIX:       radix_len = data[4:0];
      CFG_DIGITS_LOW:  alphabet[63:0] = data;
      CFG_DIGITS_HIGH: alphabet[127:64] = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait out every expected char, then the longest possible silent item
  task automatic drain();
    start = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic load_alphabet(input logic [63:0] radix_data, input logic [63:0] lo,
                               input logic [63:0] hi);
    drain();
    write_reg(CFG_RADIX, radix_data);
    write_reg(CFG_DIGITS_LOW, lo);
    write_reg(CFG_DIGITS_HIGH, hi);
    alphabet_loads++;
  endtask

  task automatic send_value(input logic [31:0] v);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 80)) @(negedge clk_i);
    end
    start   = 1'b1;
    value_i = v;
    do @(posedge clk_i); while (busy);
    predict_chars(v);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    logic [63:0] p;
    int          r;
    r = (radix_len >= 2 && radix_len <= MAX_RADIX) ? radix_len : 10;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(1) ? 32'($urandom_range(300)) : -32'($urandom_range(300));
      5: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0000;
          3: return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      6, 7: begin
        p = 64'd1;
        repeat ($urandom_range(31)) if (p * r <= 64'h8000_0000) p = p * r;
        p = p + $urandom_range(2) - 1;
        return $urandom_range(1) ? p[31:0] : -p[31:0];
      end
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [7:0] bad_glyph();
    case ($urandom_range(3))
      0: return 8'($urandom_range(0, 31));
      1: return 8'($urandom_range(127, 255));
      2: return CHAR_PLUS;
      default: return CHAR_MINUS;
    endcase
  endfunction

  task automatic load_random_alphabet(input bit broken);
    logic [127:0] a;
    logic [63:0]  rd;
    logic [7:0]   c;
    bit           used[256];
    int           r;
    int           i;
    r = $urandom_range(2, MAX_RADIX);
    if ($urandom_range(3) == 0) r = $urandom_range(1) ? 2 : MAX_RADIX;
    a = {$urandom, $urandom, $urandom, $urandom};
    foreach (used[k]) used[k] = 1'b0;
    for (int k = 0; k < r; k++) begin
      do c = 8'($urandom_range(32, 126)); while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
      used[c] = 1'b1;
      a[k*8 +: 8] = c;
    end
    rd = 64'(r);
    if ($urandom_range(4) == 0) begin
      rd      = {$urandom, $urandom};
      rd[4:0] = 5'(r);
    end
    if (broken) begin
      i = $urandom_range(r - 1);
      case ($urandom_range(2))
        0: rd[4:0] = $urandom_range(1) ? 5'($urandom_range(1)) : 5'($urandom_range(17, 31));
        1: a[i*8 +: 8] = bad_glyph();
        default: a[((i + $urandom_range(1, r - 1)) % r)*8 +: 8] = a[i*8 +: 8];
      endcase
    end
    load_alphabet(rd, a[63:0], a[127:64]);
  endtask

  task automatic test_decimal_reset();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd9);
    send_value(32'd10);
  endtask

  task automatic test_binary_widest();
    load_alphabet(64'd2, 64'h0000_0000_0000_3130, 64'h0);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
  endtask

  // digit zero is the lowest printable char, digit fifteen the highest
  task automatic test_hex_printable_edges();
    load_alphabet(64'd16, 64'h3736_3534_3332_3120, 64'h7e45_4443_4241_3938);
    send_value(32'hffff_ffff);
    send_value(32'd0);
    send_value(32'h1234_5678);
  endtask

  task automatic test_radix_out_of_range();
    load_alphabet(64'd0, 64'h3736_3534_3332_3130, 64'h3938);
    send_value(32'd123);
    load_alphabet(64'd1, 64'h3736_3534_3332_3130, 64'h3938);
    send_value(32'd0);
    load_alphabet(64'd17, 64'h3736_3534_3332_3130, 64'h3938);
    send_value(32'hffff_fff0);
    load_alphabet(64'hffff_ffff_ffff_ffff, 64'h3736_3534_3332_3130, 64'h3938);
    send_value(32'd77);
  endtask

  task automatic test_bad_characters();
    load_alphabet(64'd10, 64'h0, 64'h3938);
    send_value(32'd5);
    load_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'hffff_ffff_ffff_ffff);
    send_value(32'd5);
    load_alphabet(64'd10, 64'h3736_3534_2b32_3130, 64'h3938);
    send_value(32'd5);
    load_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h2d38);
    send_value(32'd5);
    load_alphabet(64'd10, 64'h3736_3534_3332_1f30, 64'h3938);
    send_value(32'd5);
    load_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h7f38);
    send_value(32'd5);
  endtask

  task automatic test_duplicates_and_spare_bytes();
    load_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h3038);
    send_value(32'd5);
    load_alphabet(64'd3, 64'h2d2b_00ff_6163_6261, 64'hffff_ffff_ffff_ffff);
    send_value(32'hffff_fffb);
    send_value(32'h8000_0000);
  endtask

  task automatic test_random_stream(input int pct, input int n_items);
    int  sent;
    int  burst;
    bit  broken;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_items) begin
      broken = ($urandom_range(9) == 0);
      load_random_alphabet(broken);
      burst = $urandom_range(15, 35);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        if ($urandom_range(39) == 0) drain();
        send_value(pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_RADIX;
    cfg_data_i  = '0;
    radix_len   = 5'd10;
    alphabet    = {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
    errors      = 0;
    cycles      = 0;
    idle_pct    = 36;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_decimal_reset();
    test_binary_widest();
    test_hex_printable_edges();
    test_radix_out_of_range();
    test_bad_characters();
    test_duplicates_and_spare_bytes();
    test_random_stream(36, 119);
    test_random_stream(51, 118);
    test_random_stream(0, 118);
    drain();

    $display("sent %0d numbers over %0d alphabet loads (%0d register writes)",
             items_sent, alphabet_loads, cfg_writes);
    $display("checked %0d characters, radix 0..31 and broken alphabets included", chars_seen);
    if (errors == 0) begin
      $display("radix_digit_formatter verification clean");
    end else begin
      $display("radix_digit_formatter verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
